// ===== sv/clw_pkg.sv =====
// Shared types and constants for the 4-bit character LCD write sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package clw_pkg;

	// Interface timing, in ticks (one tick per processed item)
	localparam int unsigned NIBBLE_WAIT_TICKS   = 100;
	localparam int unsigned POWER_ON_WAIT_TICKS = 30000;
	localparam int unsigned WAKE_WAIT_TICKS     = 4100;
	localparam int unsigned CLEAR_WAIT_TICKS    = 1600;
	localparam int unsigned SETTLE_WAIT_TICKS   = 3000;
	localparam int unsigned PLACE_WAIT_TICKS    = 40;

	localparam int unsigned WAIT_W  = 15;
	localparam int unsigned EXTRA_W = 11;
	localparam int unsigned STEP_W  = 6;

	// Action codes
	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_INIT   = 3'd1;
	localparam logic [2:0] ACT_WRITE  = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_CURSOR = 3'd4;
	localparam logic [2:0] ACT_PLACE  = 3'd5;

	// Controller command bytes
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
	localparam logic [7:0] DDRAM_BASE     = 8'h80;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] data_byte;
		logic       is_data;
		logic [1:0] cursor_bits;
		logic       row;
		logic [5:0] column;
	} clw_in_t;

	typedef struct packed {
		logic       rs_pin;
		logic       enable_pin;
		logic [3:0] data_nibble;
		logic       backlight_pin;
		logic       busy_res;
		logic       rejected;
	} clw_out_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic               is_cmd;
		logic               is_init;
		logic [7:0]         cmd_byte;
		logic               cmd_rs;
		logic [EXTRA_W-1:0] extra;
	} clw_cmd_t;

endpackage

`default_nettype wire

// ===== sv/clw_front.sv =====
// Front end: classifies an incoming item into the byte, select and extra delay to send.
// Depends on clw_pkg.
`default_nettype none

module clw_front import clw_pkg::*; (
	input  wire clw_in_t  item,
	output clw_cmd_t      cmd
);

	always_comb begin
		cmd          = '0;
		cmd.is_cmd   = 1'b1;
		unique case (item.action)
			ACT_INIT: begin
				cmd.is_init = 1'b1;
			end
			ACT_WRITE: begin
				cmd.cmd_byte = item.data_byte;
				cmd.cmd_rs   = item.is_data;
			end
			ACT_CLEAR: begin
				cmd.cmd_byte = CMD_CLEAR;
				cmd.extra    = EXTRA_W'(CLEAR_WAIT_TICKS);
			end
			ACT_CURSOR: begin
				cmd.cmd_byte = CMD_DISPLAY_ON | {6'b0, item.cursor_bits};
			end
			ACT_PLACE: begin
				cmd.cmd_byte = DDRAM_BASE | {1'b0, item.row, item.column};
				cmd.extra    = EXTRA_W'(PLACE_WAIT_TICKS);
			end
			default: begin
				// plain tick, including the unused codes
				cmd.is_cmd = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/clw_queue.sv =====
// Two-entry queue of classified items between front and back.
// Depends on clw_pkg.
`default_nettype none

module clw_queue import clw_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push,
	input  wire clw_cmd_t push_data,
	output logic          can_push,
	input  wire           pop,
	output clw_cmd_t      pop_data,
	output logic          can_pop
);

	clw_cmd_t    entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign can_push = (count_q != 2'd2);
	assign can_pop  = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/clw_back.sv =====
// Back end: nibble sequencer with wait counter, pin registers and output register.
// Depends on clw_pkg.
`default_nettype none

module clw_back import clw_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	input  wire clw_cmd_t cmd,
	input  wire           cmd_valid,
	output logic          cmd_pop,
	output logic          out_valid,
	input  wire           out_ready,
	output clw_out_t      out_item
);

	localparam logic [STEP_W-1:0] STEP_IDLE      = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_INIT      = STEP_W'(1);
	localparam logic [STEP_W-1:0] STEP_WAKE0     = STEP_W'(2);
	localparam logic [STEP_W-1:0] STEP_CLEAR_LO  = STEP_W'(11);
	localparam logic [STEP_W-1:0] STEP_INIT_LAST = STEP_W'(15);
	localparam logic [STEP_W-1:0] STEP_BYTE_HI   = STEP_W'(16);
	localparam logic [STEP_W-1:0] STEP_BYTE_LO   = STEP_W'(17);
	localparam logic [STEP_W-1:0] STEP_DRAIN     = STEP_W'(63);

	localparam logic [WAIT_W-1:0] NIBBLE_WAIT  = WAIT_W'(NIBBLE_WAIT_TICKS);
	localparam logic [WAIT_W-1:0] POWER_RELOAD = WAIT_W'(POWER_ON_WAIT_TICKS - 1);
	localparam logic [WAIT_W-1:0] WAKE_WAIT    = WAIT_W'(WAKE_WAIT_TICKS);
	localparam logic [WAIT_W-1:0] CLEAR_SETTLE_WAIT =
		WAIT_W'(NIBBLE_WAIT_TICKS + CLEAR_WAIT_TICKS + SETTLE_WAIT_TICKS);

	// Nibbles of init steps: wake-up 3,3,3,2 then bytes 0x28, 0x08, 0x01, 0x06, 0x0C
	function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] s);
		logic [3:0] nib;
		unique case (s)
			6'd2, 6'd3, 6'd4: nib = 4'h3;
			6'd5, 6'd6:       nib = 4'h2;
			6'd7, 6'd9:       nib = 4'h8;
			6'd11:            nib = 4'h1;
			6'd13:            nib = 4'h6;
			6'd15:            nib = 4'hC;
			default:          nib = 4'h0;
		endcase
		return nib;
	endfunction

	logic [STEP_W-1:0]  step_q,  n_step;
	logic [WAIT_W-1:0]  wait_q,  n_wait;
	logic [7:0]         pbyte_q, n_pbyte;
	logic               prs_q,   n_prs;
	logic [EXTRA_W-1:0] extra_q, n_extra;
	logic               rs_q,    n_rs;
	logic               en_q,    n_en;
	logic [3:0]         nib_q,   n_nib;
	logic               bl_q,    n_bl;
	logic               rej;
	logic               out_valid_q;
	clw_out_t           out_q;
	clw_out_t           n_out;

	// Take a tick whenever the output register is free or being drained
	assign cmd_pop   = cmd_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		n_step  = step_q;
		n_wait  = wait_q;
		n_pbyte = pbyte_q;
		n_prs   = prs_q;
		n_extra = extra_q;
		n_rs    = rs_q;
		n_en    = en_q;
		n_nib   = nib_q;
		n_bl    = bl_q;
		rej     = 1'b0;
		if (step_q != STEP_IDLE) begin
			rej  = cmd.is_cmd;
			n_en = 1'b0;
			if (wait_q != '0) begin
				n_wait = wait_q - WAIT_W'(1);
				if (wait_q == WAIT_W'(1) && step_q == STEP_DRAIN) begin
					n_step = STEP_IDLE;
				end
			end else begin
				case (step_q) inside
					STEP_INIT: begin
						n_bl   = 1'b1;
						n_wait = POWER_RELOAD;
						n_step = STEP_WAKE0;
					end
					[STEP_WAKE0:STEP_INIT_LAST]: begin
						n_rs   = 1'b0;
						n_nib  = init_nibble(step_q);
						n_en   = 1'b1;
						n_wait = NIBBLE_WAIT;
						if (step_q == STEP_WAKE0) begin
							n_wait = WAKE_WAIT;
						end else if (step_q == STEP_CLEAR_LO) begin
							n_wait = CLEAR_SETTLE_WAIT;
						end
						n_step = (step_q == STEP_INIT_LAST) ? STEP_DRAIN
							: step_q + STEP_W'(1);
					end
					STEP_BYTE_HI: begin
						n_rs   = prs_q;
						n_nib  = pbyte_q[7:4];
						n_en   = 1'b1;
						n_wait = NIBBLE_WAIT;
						n_step = STEP_BYTE_LO;
					end
					STEP_BYTE_LO: begin
						n_rs   = prs_q;
						n_nib  = pbyte_q[3:0];
						n_en   = 1'b1;
						n_wait = NIBBLE_WAIT + WAIT_W'(extra_q);
						n_step = STEP_DRAIN;
					end
					default: begin
						n_step = STEP_IDLE;
					end
				endcase
			end
		end else if (cmd.is_cmd) begin
			if (cmd.is_init) begin
				// power-on wait first; select keeps its level until the first nibble
				n_bl   = 1'b1;
				n_en   = 1'b0;
				n_wait = POWER_RELOAD;
				n_step = STEP_WAKE0;
			end else begin
				n_pbyte = cmd.cmd_byte;
				n_prs   = cmd.cmd_rs;
				n_extra = cmd.extra;
				n_rs    = cmd.cmd_rs;
				n_nib   = cmd.cmd_byte[7:4];
				n_en    = 1'b1;
				n_wait  = NIBBLE_WAIT;
				n_step  = STEP_BYTE_LO;
			end
		end
		n_out.rs_pin        = n_rs;
		n_out.enable_pin    = n_en;
		n_out.data_nibble   = n_nib;
		n_out.backlight_pin = n_bl;
		n_out.busy_res      = (n_step != STEP_IDLE);
		n_out.rejected      = rej;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			pbyte_q <= n_pbyte;
			prs_q   <= n_prs;
			extra_q <= n_extra;
			out_q   <= n_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			wait_q      <= '0;
			rs_q        <= 1'b0;
			en_q        <= 1'b0;
			nib_q       <= 4'h0;
			bl_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				step_q      <= n_step;
				wait_q      <= n_wait;
				rs_q        <= n_rs;
				en_q        <= n_en;
				nib_q       <= n_nib;
				bl_q        <= n_bl;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Enable strobe lasts exactly one tick
	a_enable_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && en_q) |=> !en_q)
		else $error("enable held high for more than one tick");

	// Idle only once the wait counter has run out
	a_idle_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_IDLE) |-> (wait_q == '0))
		else $error("sequencer idle with wait pending");

	// Step index never rests on the init entry or an unused step
	a_step_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != STEP_INIT) && ((step_q <= STEP_BYTE_LO) || (step_q == STEP_DRAIN)))
		else $error("illegal step index");

	// Reported busy matches the registered step after each tick
	a_busy_matches: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (out_q.busy_res == (step_q != STEP_IDLE)))
		else $error("busy flag out of step with sequencer");

endmodule

`default_nettype wire

// ===== sv/char_lcd_4bit_write_sequencer.sv =====
// Top level of the 4-bit character LCD write sequencer.
// Depends on clw_pkg, clw_front, clw_queue and clw_back.
`default_nettype none

// Every input beat is one interface tick (one microsecond of LCD time) and
// yields exactly one output beat carrying the pin levels after that tick:
// register select, enable, D7..D4 (bit 0 is D4), backlight, a busy flag, and
// a rejected flag for a command that arrived while a sequence was running.
// Actions: tick, init (power-on wait, wake-up nibbles, function set, display
// off, clear, entry mode, display on), write byte, clear, cursor mode and
// place cursor. Bytes go out high nibble first; each nibble gets a one-tick
// enable strobe and the nibble wait; the low one adds any command delay.
// Throughput is one beat per clock while the output is not stalled: the
// front classifies each beat and pushes it into a two-entry queue, and the
// back runs the sequencer's counter and step update for one tick per clock
// into an output register. A beat's result passes through the queue entry
// and then the output register; a stalled output backs up through the queue
// to in_ready.
// No clearing pass follows reset.
module char_lcd_4bit_write_sequencer import clw_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  wire clw_in_t  in_item,
	output logic          out_valid,
	input  wire           out_ready,
	output clw_out_t      out_item
);

	clw_cmd_t front_cmd;
	clw_cmd_t back_cmd;
	logic     q_can_push;
	logic     q_can_pop;
	logic     q_pop;
	logic     q_push;

	// Accept whenever the queue has room
	assign in_ready = q_can_push;
	assign q_push   = in_valid && q_can_push;

	clw_front u_front (
		.item (in_item),
		.cmd  (front_cmd)
	);

	clw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (front_cmd),
		.can_push  (q_can_push),
		.pop       (q_pop),
		.pop_data  (back_cmd),
		.can_pop   (q_can_pop)
	);

	clw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (q_can_pop),
		.cmd_pop   (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire
